[rtl/lpfd_pkg.sv]
// shared types and constants of the length-prefixed frame decoder
package lpfd_pkg;

    localparam logic [7:0] SEP_CHAR = 8'h2C;
    localparam logic [7:0] DIGIT_LO = 8'h30;
    localparam logic [7:0] DIGIT_HI = 8'h39;

    localparam logic [1:0] KIND_DATA        = 2'd0;
    localparam logic [1:0] KIND_EMPTY_STR   = 2'd1;
    localparam logic [1:0] KIND_EMPTY_FRAME = 2'd2;
    localparam logic [1:0] KIND_ERROR       = 2'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_NUMBER = 2'd1;
    localparam logic [1:0] ERR_COUNT  = 2'd2;
    localparam logic [1:0] ERR_LENGTH = 2'd3;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_SEP,
        CLS_OTHER
    } cls_t;

    // one classified input word
    typedef struct packed {
        logic [7:0] byte_val;
        cls_t       cls;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // one result word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] idx;
        logic       str_end;
        logic       frm_end;
        logic [1:0] err;
        logic       last;
    } item_t;

endpackage

[rtl/lpfd_front.sv]
// input side: accepts bytes and classifies them as digit, separator or other
module lpfd_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  lpfd_pkg::q_stat_t   q_stat,
    output logic                q_push,
    output lpfd_pkg::tok_t      q_wdata
);
    import lpfd_pkg::*;

    logic [7:0] rel;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;
    assign rel      = s_tdata - DIGIT_LO;

    always_comb begin
        q_wdata.byte_val = s_tdata;
        q_wdata.digit    = rel[3:0];
        if (s_tdata >= DIGIT_LO && s_tdata <= DIGIT_HI) begin
            q_wdata.cls = CLS_DIGIT;
        end else if (s_tdata == SEP_CHAR) begin
            q_wdata.cls = CLS_SEP;
        end else begin
            q_wdata.cls = CLS_OTHER;
        end
    end

endmodule

[rtl/lpfd_queue.sv]
// short word queue between the classifier and the parser
module lpfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lpfd_pkg::tok_t      wdata,
    input  logic                pop,
    output lpfd_pkg::tok_t      rdata,
    output lpfd_pkg::q_stat_t   stat
);
    import lpfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tok_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

endmodule

[rtl/lpfd_back.sv]
// parser and emitter: header parsing, length table, payload tagging, empty-string markers
module lpfd_back #(
    parameter int MAX_STRINGS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpfd_pkg::tok_t    tok,
    input  logic              tok_valid,
    output logic              tok_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lpfd_pkg::item_t   out_item
);
    import lpfd_pkg::*;

    localparam int CW = $clog2(MAX_STRINGS + 1);
    localparam int AW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
    localparam int NW = (LENGTH_BITS > 7) ? LENGTH_BITS : 7;
    localparam int VW = NW + 4;
    localparam logic [VW-1:0] LEN_MAX = VW'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [VW-1:0] CNT_SAT = VW'(MAX_STRINGS + 1);
    localparam logic [NW-1:0] CNT_MAX = NW'(MAX_STRINGS);

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_LENGTHS,
        ST_SCAN,
        ST_PAYLOAD
    } st_t;

    st_t                  state_reg, state_next;
    logic [NW-1:0]        acc_reg, acc_next;
    logic                 dseen_reg, dseen_next;
    logic [CW-1:0]        total_reg, total_next;
    logic [CW-1:0]        lr_reg, lr_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [LENGTH_BITS-1:0] done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;
    item_t                item_reg, item_next;

    logic [LENGTH_BITS-1:0] tbl_mem [MAX_STRINGS];
    logic [LENGTH_BITS-1:0] rd_data_reg;
    logic [MAX_STRINGS-1:0] zmask_reg;

    logic                 adv, emit, restart, tbl_we;
    logic [VW-1:0]        acc_x10;
    logic [NW-1:0]        cnt_val;
    logic [CW:0]          cur_inc, lr_inc;
    logic                 more_after_cur, cur_empty, last_string;
    logic [CW+3:0]        cur_ext;
    logic [3:0]           idx;
    logic [LENGTH_BITS:0] done_inc;

    assign adv      = !out_valid_reg || out_ready;
    assign acc_x10  = VW'({acc_reg, 3'b000}) + VW'({acc_reg, 1'b0}) + VW'(tok.digit);
    assign cnt_val  = (acc_x10 > CNT_SAT) ? NW'(CNT_SAT) : NW'(acc_x10);
    assign cur_inc  = {1'b0, cur_reg} + 1'b1;
    assign lr_inc   = {1'b0, lr_reg} + 1'b1;
    assign cur_ext  = {4'b0000, cur_reg};
    assign idx      = cur_ext[3:0];
    assign done_inc = {1'b0, done_reg} + 1'b1;
    assign last_string = (cur_inc >= {1'b0, total_reg});
    // the next string is an empty one, so another marker follows in this run
    assign more_after_cur = !last_string && zmask_reg[cur_inc[AW-1:0]];
    assign cur_empty = (cur_reg < total_reg) && zmask_reg[cur_reg[AW-1:0]];

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        dseen_next  = dseen_reg;
        total_next  = total_reg;
        lr_next     = lr_reg;
        cur_next    = cur_reg;
        done_next   = done_reg;
        item_next   = item_reg;
        emit        = 1'b0;
        restart     = 1'b0;
        tbl_we      = 1'b0;
        tok_pop     = 1'b0;

        if (adv) begin
            unique case (state_reg)
                ST_COUNT: begin
                    if (tok_valid) begin
                        tok_pop = 1'b1;
                        unique case (tok.cls)
                            CLS_DIGIT: begin
                                acc_next   = cnt_val;
                                dseen_next = 1'b1;
                            end
                            CLS_SEP: begin
                                if (!dseen_reg) begin
                                    emit      = 1'b1;
                                    restart   = 1'b1;
                                    item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                                  ERR_NUMBER, 1'b1};
                                end else if (acc_reg > CNT_MAX) begin
                                    emit      = 1'b1;
                                    restart   = 1'b1;
                                    item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                                  ERR_COUNT, 1'b1};
                                end else if (acc_reg == '0) begin
                                    emit      = 1'b1;
                                    restart   = 1'b1;
                                    item_next = '{KIND_EMPTY_FRAME, 8'd0, 4'd0, 1'b0, 1'b1,
                                                  ERR_NONE, 1'b1};
                                end else begin
                                    total_next = acc_reg[CW-1:0];
                                    lr_next    = '0;
                                    acc_next   = '0;
                                    dseen_next = 1'b0;
                                    state_next = ST_LENGTHS;
                                end
                            end
                            CLS_OTHER: begin
                                emit      = 1'b1;
                                restart   = 1'b1;
                                item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                              ERR_NUMBER, 1'b1};
                            end
                        endcase
                    end
                end
                ST_LENGTHS: begin
                    if (tok_valid) begin
                        tok_pop = 1'b1;
                        unique case (tok.cls)
                            CLS_DIGIT: begin
                                if (acc_x10 > LEN_MAX) begin
                                    emit      = 1'b1;
                                    restart   = 1'b1;
                                    item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                                  ERR_LENGTH, 1'b1};
                                end else begin
                                    acc_next   = NW'(acc_x10);
                                    dseen_next = 1'b1;
                                end
                            end
                            CLS_SEP: begin
                                if (!dseen_reg) begin
                                    emit      = 1'b1;
                                    restart   = 1'b1;
                                    item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                                  ERR_NUMBER, 1'b1};
                                end else begin
                                    tbl_we     = (lr_reg < CW'(MAX_STRINGS));
                                    lr_next    = lr_inc[CW-1:0];
                                    acc_next   = '0;
                                    dseen_next = 1'b0;
                                    if (lr_inc >= {1'b0, total_reg}) begin
                                        cur_next   = '0;
                                        state_next = ST_SCAN;
                                    end
                                end
                            end
                            CLS_OTHER: begin
                                emit      = 1'b1;
                                restart   = 1'b1;
                                item_next = '{KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0,
                                              ERR_NUMBER, 1'b1};
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (cur_empty) begin
                        emit      = 1'b1;
                        item_next = '{KIND_EMPTY_STR, 8'd0, idx, 1'b1, last_string,
                                      ERR_NONE, !more_after_cur};
                        cur_next  = cur_inc[CW-1:0];
                    end else if (cur_reg >= total_reg) begin
                        restart = 1'b1;
                    end else begin
                        done_next  = '0;
                        state_next = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    if (tok_valid) begin
                        tok_pop = 1'b1;
                        emit    = 1'b1;
                        if (done_inc == {1'b0, rd_data_reg}) begin
                            item_next  = '{KIND_DATA, tok.byte_val, idx, 1'b1, last_string,
                                           ERR_NONE, !more_after_cur};
                            cur_next   = cur_inc[CW-1:0];
                            done_next  = '0;
                            state_next = ST_SCAN;
                        end else begin
                            item_next = '{KIND_DATA, tok.byte_val, idx, 1'b0, 1'b0,
                                          ERR_NONE, 1'b1};
                            done_next = done_inc[LENGTH_BITS-1:0];
                        end
                    end
                end
                default: begin
                    state_next = ST_COUNT;
                end
            endcase
        end

        if (restart) begin
            state_next = ST_COUNT;
            acc_next   = '0;
            dseen_next = 1'b0;
            total_next = '0;
            lr_next    = '0;
            cur_next   = '0;
            done_next  = '0;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COUNT;
            acc_reg       <= '0;
            dseen_reg     <= 1'b0;
            total_reg     <= '0;
            lr_reg        <= '0;
            cur_reg       <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            dseen_reg     <= dseen_next;
            total_reg     <= total_next;
            lr_reg        <= lr_next;
            cur_reg       <= cur_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg <= item_next;
    end

    // length table; zero flags kept beside it for the empty-string search
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[lr_reg[AW-1:0]]   <= acc_reg[LENGTH_BITS-1:0];
            zmask_reg[lr_reg[AW-1:0]] <= (acc_reg == '0);
        end
        rd_data_reg <= tbl_mem[cur_reg[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_STRINGS))
        else $error("string count above table size");

    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PAYLOAD |-> (rd_data_reg != '0 && cur_reg < total_reg))
        else $error("payload with empty or out-of-frame string");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((item_reg.kind == KIND_ERROR) == (item_reg.err != ERR_NONE)))
        else $error("error code does not match item kind");

    a_scan_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cur_reg <= total_reg)
        else $error("string index past frame during scan");

endmodule

[rtl/length_prefix_frame_decoder.sv]
// path: an accepted byte goes through the queue and its first result is registered in
// the output item; the final length comma leads to the scan state before any marker
// throughput: one byte per cycle in header and payload while the output is taken;
// each string end and the end of the length list add a scan step for the table lookup,
// and each empty-string marker takes its own scan step
// reset: synchronous active-low aresetn clears parser, queue and output valid, not the table
module length_prefix_frame_decoder #(
    parameter int MAX_STRINGS = 16,
    parameter int LENGTH_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [11:8] string_index,
                                   // [12] string_end, [13] frame_end, [15:14] error_code
    output logic [1:0]  m_tuser,   // [1:0] item_kind
    output logic        m_tlast    // last_of_run
);
    import lpfd_pkg::*;

    q_stat_t q_stat;
    tok_t    q_wdata;
    tok_t    q_rdata;
    logic    q_push;
    logic    q_pop;
    item_t   item;

    lpfd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    lpfd_back #(
        .MAX_STRINGS (MAX_STRINGS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok       (q_rdata),
        .tok_valid (!q_stat.empty),
        .tok_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {item.err, item.frm_end, item.str_end, item.idx, item.data};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

endmodule
